[rtl/core/sdt_pkg.sv]
// Shared types, widths and constants for the Sobel double threshold classifier.
// Used by every module in rtl/core; depends on nothing.
package sdt_pkg;

  localparam int MAX_WIDTH_DEF = 4096;

  localparam int SUM_W  = 10;
  localparam int POS_W  = 12;
  localparam int SIZE_W = 13;
  localparam int THR_W  = 21;
  localparam int GRAD_W = 13;
  localparam int SQ_W   = 24;
  localparam int MAG_W  = 25;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam int SIZE_MIN = 3;
  localparam int SIZE_MAX = 4096;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [THR_W-1:0]  LOW_RST    = 21'd5000;
  localparam logic [THR_W-1:0]  HIGH_RST   = 21'd35000;

  localparam logic [1:0] CLASS_NONE   = 2'd0;
  localparam logic [1:0] CLASS_WEAK   = 2'd1;
  localparam logic [1:0] CLASS_STRONG = 2'd2;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_LOW_THRESHOLD,
    REG_HIGH_THRESHOLD
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;
    logic [1:0]       edge_class;
    logic             last_of_frame;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } meta_t;

  typedef struct packed {
    logic [POS_W-1:0] width_m1;
    logic [POS_W-1:0] height_m1;
    logic [MAG_W-1:0] low9;
    logic [MAG_W-1:0] high9;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] upper;
    logic [SUM_W-1:0] middle;
  } line_pair_t;

  localparam int LINE_PAIR_W = 2 * SUM_W;

  typedef logic [2:0][2:0][SUM_W-1:0] win_t;

endpackage

[rtl/core/sobel_double_threshold_classifier.sv]
// Sobel 3x3 double threshold edge classifier: top level with position counters.
// One pixel per cycle is sustained while res_stall does not hold the output.
// Each pixel does one read-modify-write of the line memory (read on accept, write as it leaves s1).
// Reset clears the counters, the window, the pipeline and the registers; line memory is not cleared.
// Depends on sdt_pkg, sdt_regs, sdt_window (with sdt_ram) and sdt_grad.
module sobel_double_threshold_classifier #(
  parameter int MAX_WIDTH = sdt_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pix_valid,
  output logic                       pix_stall,
  input  sdt_pkg::pixel_t            pix,
  output logic                       res_valid,
  input  logic                       res_stall,
  output sdt_pkg::result_t           res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sdt_pkg::APB_AW-1:0] paddr,
  input  logic [sdt_pkg::APB_DW-1:0] pwdata,
  output logic [sdt_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int AW = $clog2(MAX_WIDTH);

  sdt_pkg::cfg_t              cfg;
  logic                       accept;
  logic [sdt_pkg::POS_W-1:0]  col_cnt;
  logic [sdt_pkg::POS_W-1:0]  row_cnt;
  logic [sdt_pkg::POS_W-1:0]  col_cnt_next;
  logic [sdt_pkg::POS_W-1:0]  row_cnt_next;
  logic [sdt_pkg::POS_W-1:0]  c_cur;
  logic [sdt_pkg::POS_W-1:0]  r_cur;
  logic [AW-1:0]              addr_in;
  logic [sdt_pkg::SUM_W-1:0]  sum_in;
  sdt_pkg::meta_t             meta_in;
  logic                       emit_in;

  logic                       v1;
  logic [sdt_pkg::SUM_W-1:0]  s1_sum;
  logic [AW-1:0]              s1_addr;
  sdt_pkg::meta_t             s1_meta;
  logic                       s1_emit;
  logic                       v2;
  sdt_pkg::meta_t             s2_meta;
  logic                       go1;
  logic                       go2;
  logic                       grad_ready;
  sdt_pkg::win_t              win;

  sdt_regs #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  assign go2       = v2 && grad_ready;
  assign go1       = v1 && (!v2 || go2);
  assign pix_stall = v1 && !go1;
  assign accept    = pix_valid && !pix_stall;

  always_comb begin
    c_cur   = pix.frame_start ? '0 : col_cnt;
    r_cur   = pix.frame_start ? '0 : row_cnt;
    addr_in = AW'(c_cur);
    sum_in  = sdt_pkg::SUM_W'(pix.red) + sdt_pkg::SUM_W'(pix.green)
            + sdt_pkg::SUM_W'(pix.blue);
    emit_in = (r_cur >= 12'd2) && (c_cur >= 12'd2);
    meta_in.row  = r_cur - 12'd1;
    meta_in.col  = c_cur - 12'd1;
    meta_in.last = (r_cur == cfg.height_m1) && (c_cur == cfg.width_m1);
    if (c_cur >= cfg.width_m1) begin
      col_cnt_next = '0;
      row_cnt_next = (r_cur >= cfg.height_m1) ? '0 : r_cur + 12'd1;
    end else begin
      col_cnt_next = c_cur + 12'd1;
      row_cnt_next = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt <= col_cnt_next;
        row_cnt <= row_cnt_next;
        v1      <= 1'b1;
      end else if (go1) begin
        v1 <= 1'b0;
      end
      if (go1) begin
        v2 <= s1_emit;
      end else if (go2) begin
        v2 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sum  <= sum_in;
      s1_addr <= addr_in;
      s1_meta <= meta_in;
      s1_emit <= emit_in;
    end
    if (go1) begin
      s2_meta <= s1_meta;
    end
  end

  sdt_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(addr_in),
    .shift  (go1),
    .wr_addr(s1_addr),
    .sum    (s1_sum),
    .win    (win)
  );

  sdt_grad u_grad (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .in_ready (grad_ready),
    .win      (win),
    .meta     (s2_meta),
    .low9     (cfg.low9),
    .high9    (cfg.high9),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

endmodule

[rtl/core/sdt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on sdt_pkg for its default sizes.
module sdt_ram #(
  parameter int WIDTH = sdt_pkg::LINE_PAIR_W,
  parameter int DEPTH = sdt_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/sdt_regs.sv]
// APB-style configuration registers with their clamped and scaled copies.
// Depends on sdt_pkg for the register map, reset values and cfg_t.
module sdt_regs #(
  parameter int MAX_WIDTH = sdt_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdt_pkg::APB_AW-1:0]  paddr,
  input  logic [sdt_pkg::APB_DW-1:0]  pwdata,
  output logic [sdt_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output sdt_pkg::cfg_t               cfg
);

  localparam int WCAP = (MAX_WIDTH < sdt_pkg::SIZE_MAX) ? MAX_WIDTH : sdt_pkg::SIZE_MAX;

  logic [sdt_pkg::SIZE_W-1:0] image_width;
  logic [sdt_pkg::SIZE_W-1:0] image_height;
  logic [sdt_pkg::THR_W-1:0]  low_threshold;
  logic [sdt_pkg::THR_W-1:0]  high_threshold;
  logic                       wr;
  sdt_pkg::reg_idx_t          idx;

  function automatic logic [sdt_pkg::POS_W-1:0] size_m1(
    input logic [sdt_pkg::SIZE_W-1:0] v,
    input logic [sdt_pkg::SIZE_W-1:0] cap
  );
    logic [sdt_pkg::SIZE_W-1:0] r;
    if (v < sdt_pkg::SIZE_W'(sdt_pkg::SIZE_MIN)) begin
      r = sdt_pkg::SIZE_W'(sdt_pkg::SIZE_MIN - 1);
    end else if (v > cap) begin
      r = cap - 13'd1;
    end else begin
      r = v - 13'd1;
    end
    return r[sdt_pkg::POS_W-1:0];
  endfunction

  function automatic logic [sdt_pkg::MAG_W-1:0] times9(input logic [sdt_pkg::THR_W-1:0] v);
    return {v, 3'b000} + sdt_pkg::MAG_W'(v);
  endfunction

  assign wr     = psel && penable && pwrite;
  assign idx    = sdt_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= sdt_pkg::WIDTH_RST;
      image_height   <= sdt_pkg::HEIGHT_RST;
      low_threshold  <= sdt_pkg::LOW_RST;
      high_threshold <= sdt_pkg::HIGH_RST;
      cfg.width_m1   <= size_m1(sdt_pkg::WIDTH_RST, sdt_pkg::SIZE_W'(WCAP));
      cfg.height_m1  <= size_m1(sdt_pkg::HEIGHT_RST, sdt_pkg::SIZE_W'(sdt_pkg::SIZE_MAX));
      cfg.low9       <= times9(sdt_pkg::LOW_RST);
      cfg.high9      <= times9(sdt_pkg::HIGH_RST);
    end else if (wr) begin
      unique case (idx)
        sdt_pkg::REG_IMAGE_WIDTH: begin
          image_width  <= pwdata[sdt_pkg::SIZE_W-1:0];
          cfg.width_m1 <= size_m1(pwdata[sdt_pkg::SIZE_W-1:0], sdt_pkg::SIZE_W'(WCAP));
        end
        sdt_pkg::REG_IMAGE_HEIGHT: begin
          image_height  <= pwdata[sdt_pkg::SIZE_W-1:0];
          cfg.height_m1 <= size_m1(pwdata[sdt_pkg::SIZE_W-1:0],
                                   sdt_pkg::SIZE_W'(sdt_pkg::SIZE_MAX));
        end
        sdt_pkg::REG_LOW_THRESHOLD: begin
          low_threshold <= pwdata[sdt_pkg::THR_W-1:0];
          cfg.low9      <= times9(pwdata[sdt_pkg::THR_W-1:0]);
        end
        sdt_pkg::REG_HIGH_THRESHOLD: begin
          high_threshold <= pwdata[sdt_pkg::THR_W-1:0];
          cfg.high9      <= times9(pwdata[sdt_pkg::THR_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sdt_pkg::REG_IMAGE_WIDTH:    prdata = sdt_pkg::APB_DW'(image_width);
      sdt_pkg::REG_IMAGE_HEIGHT:   prdata = sdt_pkg::APB_DW'(image_height);
      sdt_pkg::REG_LOW_THRESHOLD:  prdata = sdt_pkg::APB_DW'(low_threshold);
      sdt_pkg::REG_HIGH_THRESHOLD: prdata = sdt_pkg::APB_DW'(high_threshold);
      default:                     prdata = '0;
    endcase
  end

endmodule

[rtl/core/sdt_window.sv]
// Line memory read-modify-write with write forwarding, and the 3x3 window of channel sums.
// Depends on sdt_pkg and sdt_ram.
module sdt_window #(
  parameter int MAX_WIDTH = sdt_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         shift,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [sdt_pkg::SUM_W-1:0]    sum,
  output sdt_pkg::win_t                win
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [sdt_pkg::LINE_PAIR_W-1:0] ram_rdata;
  sdt_pkg::line_pair_t             col_rd;
  sdt_pkg::line_pair_t             wr_data;
  logic                            fwd_valid;
  logic [AW-1:0]                   fwd_addr;
  sdt_pkg::line_pair_t             fwd_data;

  sdt_ram #(
    .WIDTH(sdt_pkg::LINE_PAIR_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (shift),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // The item in flight may read the column that the previous item writes on the same edge.
  always_comb begin
    if (fwd_valid && fwd_addr == wr_addr) begin
      col_rd = fwd_data;
    end else begin
      col_rd = sdt_pkg::line_pair_t'(ram_rdata);
    end
    wr_data.upper  = col_rd.middle;
    wr_data.middle = sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      win       <= '0;
    end else if (shift) begin
      fwd_valid <= 1'b1;
      fwd_addr  <= wr_addr;
      fwd_data  <= wr_data;
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= col_rd.upper;
      win[1][2] <= col_rd.middle;
      win[2][2] <= sum;
    end
  end

endmodule

[rtl/core/sdt_grad.sv]
// Sobel gradients, squared magnitude and double threshold, in three pipeline stages.
// Depends on sdt_pkg for the window, metadata and result types.
module sdt_grad (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sdt_pkg::win_t             win,
  input  sdt_pkg::meta_t            meta,
  input  logic [sdt_pkg::MAG_W-1:0] low9,
  input  logic [sdt_pkg::MAG_W-1:0] high9,
  output logic                      res_valid,
  input  logic                      res_stall,
  output sdt_pkg::result_t          res
);

  logic                             va;
  logic                             vb;
  logic                             ready_a;
  logic                             ready_b;
  logic                             ready_c;
  logic signed [sdt_pkg::GRAD_W-1:0] gx;
  logic signed [sdt_pkg::GRAD_W-1:0] gy;
  logic signed [sdt_pkg::GRAD_W-1:0] gx_a;
  logic signed [sdt_pkg::GRAD_W-1:0] gy_a;
  logic signed [2*sdt_pkg::GRAD_W-1:0] gx_w;
  logic signed [2*sdt_pkg::GRAD_W-1:0] gy_w;
  logic signed [2*sdt_pkg::GRAD_W-1:0] sqx_full;
  logic signed [2*sdt_pkg::GRAD_W-1:0] sqy_full;
  logic [sdt_pkg::SQ_W-1:0]         sqx;
  logic [sdt_pkg::SQ_W-1:0]         sqy;
  logic [sdt_pkg::MAG_W-1:0]        mag;
  logic [1:0]                       cls;
  sdt_pkg::meta_t                   meta_a;
  sdt_pkg::meta_t                   meta_b;

  function automatic logic signed [sdt_pkg::GRAD_W-1:0] sx(input logic [sdt_pkg::SUM_W-1:0] v);
    return $signed({{(sdt_pkg::GRAD_W - sdt_pkg::SUM_W){1'b0}}, v});
  endfunction

  assign ready_c  = !res_valid || !res_stall;
  assign ready_b  = !vb || ready_c;
  assign ready_a  = !va || ready_b;
  assign in_ready = ready_a;

  always_comb begin
    gx = (sx(win[0][0]) + (sx(win[1][0]) <<< 1) + sx(win[2][0]))
       - (sx(win[0][2]) + (sx(win[1][2]) <<< 1) + sx(win[2][2]));
    gy = (sx(win[0][0]) + (sx(win[0][1]) <<< 1) + sx(win[0][2]))
       - (sx(win[2][0]) + (sx(win[2][1]) <<< 1) + sx(win[2][2]));
    gx_w     = gx_a;
    gy_w     = gy_a;
    sqx_full = gx_w * gx_w;
    sqy_full = gy_w * gy_w;
    mag      = sdt_pkg::MAG_W'(sqx) + sdt_pkg::MAG_W'(sqy);
    if (mag < low9) begin
      cls = sdt_pkg::CLASS_NONE;
    end else if (mag < high9) begin
      cls = sdt_pkg::CLASS_WEAK;
    end else begin
      cls = sdt_pkg::CLASS_STRONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ready_a) begin
        va <= in_valid;
      end
      if (ready_b) begin
        vb <= va;
      end
      if (ready_c) begin
        res_valid <= vb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      gx_a   <= gx;
      gy_a   <= gy;
      meta_a <= meta;
    end
    if (ready_b) begin
      sqx    <= sqx_full[sdt_pkg::SQ_W-1:0];
      sqy    <= sqy_full[sdt_pkg::SQ_W-1:0];
      meta_b <= meta_a;
    end
    if (ready_c) begin
      res.center_row    <= meta_b.row;
      res.center_col    <= meta_b.col;
      res.edge_class    <= cls;
      res.last_of_frame <= meta_b.last;
    end
  end

endmodule

[rtl/core/sdt_checker.sv]
// Port-level checks for the Sobel double threshold classifier, bound to the top level.
// Depends on sdt_pkg for the result type and the class codes.
module sdt_checker (
  input logic             clk,
  input logic             rst,
  input logic             pix_valid,
  input logic             pix_stall,
  input logic             res_valid,
  input logic             res_stall,
  input sdt_pkg::result_t res,
  input logic             pready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result valid right after reset.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("Stalled result changed or was dropped.");

  a_class_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.edge_class == sdt_pkg::CLASS_NONE
               || res.edge_class == sdt_pkg::CLASS_WEAK
               || res.edge_class == sdt_pkg::CLASS_STRONG)
    else $error("Result carries an unknown edge class.");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.center_row != '0 && res.center_col != '0 && pready)
    else $error("Result placed on the top row or left column.");

  a_stall_needs_work: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |-> res_valid && res_stall)
    else $error("Input stalled while the output side was not stalled.");

endmodule

bind sobel_double_threshold_classifier sdt_checker u_sdt_checker (
  .clk      (clk),
  .rst      (rst),
  .pix_valid(pix_valid),
  .pix_stall(pix_stall),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res      (res),
  .pready   (pready)
);
